>>> rtl/line_checksum_ack_link_core_defines.svh
// Assertion macros used by the line checksum link back end.
`ifndef LINE_CHECKSUM_ACK_LINK_CORE_DEFINES_SVH
`define LINE_CHECKSUM_ACK_LINK_CORE_DEFINES_SVH

// cond must never hold outside reset
`define LCAL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define LCAL_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/lcal_pkg.sv
// Types and constants of the line checksum link.
package lcal_pkg;

  // input kinds
  localparam logic [1:0] KIND_LINK  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_SRC   = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  // result status codes
  localparam logic [2:0] STS_NONE    = 3'd0;
  localparam logic [2:0] STS_LINE    = 3'd1;
  localparam logic [2:0] STS_BADSUM  = 3'd2;
  localparam logic [2:0] STS_TIMEOUT = 3'd3;
  localparam logic [2:0] STS_JOBEND  = 3'd4;
  localparam logic [2:0] STS_ABORT   = 3'd5;
  localparam logic [2:0] STS_BELL    = 3'd6;

  // link characters
  localparam logic [7:0] CHR_ACK   = 8'h06;
  localparam logic [7:0] CHR_NAK   = 8'h15;
  localparam logic [7:0] CHR_BEL   = 8'h07;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_EOF   = 8'h1a;
  localparam logic [7:0] CHR_QUOTE = 8'h27;

  localparam logic [7:0] SUM_RX_MASK     = 8'h7f;
  localparam logic [7:0] ERR_MAX         = 8'hff;
  localparam logic [7:0] ERR_LIMIT_RESET = 8'd10;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 1'd1;

  // line length field, wide enough for the largest line depth (63)
  localparam int unsigned LEN_W = 6;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       source_end;
  } item_t;

  typedef struct packed {
    logic       link_valid;
    logic [7:0] link_byte;
    logic       sink_valid;
    logic [7:0] sink_byte;
    logic [2:0] status;
    logic       overflow;
    logic [7:0] error_total;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    CMD_SINGLE,
    CMD_DELIVER,
    CMD_SEND,
    CMD_SEND_END
  } cmd_op_e;

  // At most one command per accepted transaction; it yields the whole result group.
  typedef struct packed {
    cmd_op_e          op;
    logic             link_valid;
    logic [7:0]       link_byte;
    logic [2:0]       status;
    logic             ovf_a;
    logic [7:0]       err_a;
    logic             abort;
    logic             ovf_b;
    logic [7:0]       err_b;
    logic [LEN_W-1:0] len;
    logic [7:0]       sum;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage

>>> rtl/lcal_front.sv
// Front end: protocol state, line gathering and command generation.
module lcal_front #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_valid_i,
  input  lcal_pkg::item_t                    item_i,
  output logic                               full_o,
  input  logic                               cfg_we_i,
  input  logic [lcal_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcal_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               cmd_push_o,
  output lcal_pkg::cmd_t                     cmd_o,
  input  logic                               fifo_full_i,
  output lcal_pkg::store_wr_t                store_wr_o,
  input  logic                               walk_done_i
);
  import lcal_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_DEPTH + 1);

  typedef enum logic [2:0] {
    F_IDLE,
    F_RXDATA,
    F_RXCHECK,
    F_TXFILL,
    F_TXWAIT,
    F_DONE
  } front_state_e;

  front_state_e    state_q, state_d;
  logic [7:0]      sum_q, sum_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      err_q, err_d;
  logic            ending_q, ending_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      last_byte_q, last_byte_d;
  logic            reader_q, reader_d;
  logic            dir_q;
  logic [7:0]      limit_q;

  logic       accept;
  logic [7:0] err_inc;
  logic       abort;
  logic [7:0] b;

  assign full_o  = fifo_full_i | reader_q;
  assign accept  = item_valid_i & ~full_o;
  assign err_inc = (err_q == ERR_MAX) ? err_q : err_q + 8'd1;
  assign abort   = err_inc > limit_q;
  assign b       = item_i.data_byte;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    len_d       = len_q;
    err_d       = err_q;
    ending_d    = ending_q;
    ovf_d       = ovf_q;
    last_byte_d = last_byte_q;
    reader_d    = reader_q;
    cmd_push_o  = 1'b0;
    cmd_o       = '0;
    store_wr_o  = '0;

    if (walk_done_i) begin
      reader_d = 1'b0;
    end

    if (accept) begin
      if (item_i.kind == KIND_START) begin
        len_d    = '0;
        sum_d    = '0;
        ovf_d    = 1'b0;
        err_d    = '0;
        ending_d = 1'b0;
        state_d  = dir_q ? F_TXFILL : F_RXDATA;
      end else begin
        unique case (state_q)
          F_RXDATA, F_RXCHECK: begin
            if (item_i.kind == KIND_TICK) begin
              cmd_push_o       = 1'b1;
              cmd_o.op         = CMD_SINGLE;
              cmd_o.link_valid = 1'b1;
              cmd_o.link_byte  = CHR_NAK;
              cmd_o.status     = STS_TIMEOUT;
              cmd_o.ovf_a      = ovf_q;
              cmd_o.err_a      = err_q;
              cmd_o.abort      = abort;
              cmd_o.err_b      = err_inc;
              len_d            = '0;
              sum_d            = '0;
              ovf_d            = 1'b0;
              err_d            = err_inc;
              state_d          = abort ? F_DONE : F_RXDATA;
            end else if (item_i.kind == KIND_LINK && state_q == F_RXDATA) begin
              if (b != CHR_CR) begin
                if (len_q < LenW'(LINE_DEPTH)) begin
                  store_wr_o.en   = 1'b1;
                  store_wr_o.addr = LEN_W'(len_q);
                  store_wr_o.data = b;
                  len_d           = len_q + 1'b1;
                  last_byte_d     = b;
                end else begin
                  ovf_d = 1'b1;
                end
              end else begin
                state_d = F_RXCHECK;
              end
              sum_d = (sum_q + b) & SUM_RX_MASK;
            end else if (item_i.kind == KIND_LINK) begin
              cmd_push_o = 1'b1;
              cmd_o.ovf_a = ovf_q;
              cmd_o.err_a = err_q;
              len_d       = '0;
              sum_d       = '0;
              ovf_d       = 1'b0;
              state_d     = F_RXDATA;
              if (b != sum_q) begin
                cmd_o.op         = CMD_SINGLE;
                cmd_o.link_valid = 1'b1;
                cmd_o.link_byte  = CHR_NAK;
                cmd_o.status     = STS_BADSUM;
                cmd_o.abort      = abort;
                cmd_o.err_b      = err_inc;
                err_d            = err_inc;
                if (abort) begin
                  state_d = F_DONE;
                end
              end else if (len_q != '0 && last_byte_q == CHR_EOF) begin
                cmd_o.op         = CMD_SINGLE;
                cmd_o.link_valid = 1'b1;
                cmd_o.link_byte  = CHR_ACK;
                cmd_o.status     = STS_JOBEND;
                state_d          = F_DONE;
              end else begin
                cmd_o.op  = CMD_DELIVER;
                cmd_o.len = LEN_W'(len_q);
                reader_d  = 1'b1;
              end
            end
          end
          F_TXFILL: begin
            if (item_i.kind == KIND_SRC) begin
              if (item_i.source_end) begin
                len_d      = '0;
                sum_d      = '0;
                ovf_d      = 1'b0;
                ending_d   = 1'b1;
                cmd_push_o = 1'b1;
                cmd_o.op   = CMD_SEND_END;
                cmd_o.err_a = err_q;
                state_d    = F_TXWAIT;
              end else if (b == CHR_LF) begin
                if (len_q < LenW'(LINE_DEPTH)) begin
                  store_wr_o.en   = 1'b1;
                  store_wr_o.addr = LEN_W'(len_q);
                  store_wr_o.data = CHR_CR;
                  len_d           = len_q + 1'b1;
                  sum_d           = sum_q + CHR_CR;
                end
                cmd_push_o  = 1'b1;
                cmd_o.op    = CMD_SEND;
                cmd_o.len   = LEN_W'(len_d);
                cmd_o.sum   = sum_d;
                cmd_o.ovf_a = ovf_q;
                cmd_o.err_a = err_q;
                reader_d    = 1'b1;
                state_d     = F_TXWAIT;
              end else if (len_q < LenW'(LINE_DEPTH - 1)) begin
                store_wr_o.en   = 1'b1;
                store_wr_o.addr = LEN_W'(len_q);
                store_wr_o.data = b;
                len_d           = len_q + 1'b1;
                sum_d           = sum_q + b;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end
          F_TXWAIT: begin
            if (item_i.kind == KIND_TICK) begin
              cmd_push_o   = 1'b1;
              cmd_o.op     = CMD_SINGLE;
              cmd_o.status = STS_TIMEOUT;
              cmd_o.ovf_a  = ovf_q;
              cmd_o.err_a  = err_q;
              cmd_o.abort  = abort;
              cmd_o.ovf_b  = ovf_q;
              cmd_o.err_b  = err_inc;
              err_d        = err_inc;
              if (abort) begin
                state_d = F_DONE;
              end
            end else if (item_i.kind == KIND_LINK) begin
              case (b)
                CHR_ACK: begin
                  cmd_push_o   = 1'b1;
                  cmd_o.op     = CMD_SINGLE;
                  cmd_o.status = ending_q ? STS_JOBEND : STS_LINE;
                  cmd_o.ovf_a  = ovf_q;
                  cmd_o.err_a  = err_q;
                  state_d      = ending_q ? F_DONE : F_TXFILL;
                  len_d        = '0;
                  sum_d        = '0;
                  ovf_d        = 1'b0;
                end
                CHR_NAK: begin
                  cmd_push_o  = 1'b1;
                  cmd_o.ovf_a = ovf_q;
                  cmd_o.err_a = err_inc;
                  err_d       = err_inc;
                  if (abort) begin
                    cmd_o.op     = CMD_SINGLE;
                    cmd_o.status = STS_ABORT;
                    state_d      = F_DONE;
                  end else if (ending_q) begin
                    cmd_o.op = CMD_SEND_END;
                  end else begin
                    cmd_o.op  = CMD_SEND;
                    cmd_o.len = LEN_W'(len_q);
                    cmd_o.sum = sum_q;
                    reader_d  = 1'b1;
                  end
                end
                CHR_BEL: begin
                  cmd_push_o   = 1'b1;
                  cmd_o.op     = CMD_SINGLE;
                  cmd_o.status = STS_BELL;
                  cmd_o.ovf_a  = ovf_q;
                  cmd_o.err_a  = err_q;
                  state_d      = F_DONE;
                end
                default: begin
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      sum_q       <= '0;
      len_q       <= '0;
      err_q       <= '0;
      ending_q    <= 1'b0;
      ovf_q       <= 1'b0;
      last_byte_q <= '0;
      reader_q    <= 1'b0;
      dir_q       <= 1'b0;
      limit_q     <= ERR_LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      len_q       <= len_d;
      err_q       <= err_d;
      ending_q    <= ending_d;
      ovf_q       <= ovf_d;
      last_byte_q <= last_byte_d;
      reader_q    <= reader_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DIRECTION:   dir_q   <= cfg_data_i[0];
          REG_ERROR_LIMIT: limit_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/lcal_cmd_fifo.sv
// Short command queue between front and back end.
module lcal_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcal_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output lcal_pkg::cmd_t data_o,
  output logic           empty_o
);
  import lcal_pkg::*;

  localparam int unsigned PtrW = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            slots_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(CMD_FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/lcal_back.sv
// Back end: line store, command execution and result register.
`include "line_checksum_ack_link_core_defines.svh"

module lcal_back #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  lcal_pkg::cmd_t      fifo_data_i,
  output logic                fifo_pop_o,
  input  lcal_pkg::store_wr_t store_wr_i,
  output logic                walk_done_o,
  output logic                res_valid_o,
  output lcal_pkg::result_t   res_o,
  input  logic                res_pop_i
);
  import lcal_pkg::*;

  localparam int unsigned IdxW = $clog2(LINE_DEPTH);

  typedef enum logic [3:0] {
    B_IDLE,
    B_SINGLE,
    B_ABORT,
    B_WALK,
    B_TAIL,
    B_ACK,
    B_END1,
    B_END2,
    B_END3
  } back_state_e;

  back_state_e     state_q;
  cmd_t            cmd_q;
  logic [IdxW-1:0] idx_q, idx_next, rd_addr;
  logic [7:0]      store_mem [LINE_DEPTH];
  logic [7:0]      rdata_q;
  result_t         res_q;
  logic            res_valid_q;
  logic            walk_done_q;
  logic            can_emit;
  logic            walk_last;
  logic            is_deliver;
  logic            res_load;
  logic            walk_end;
  logic            in_walk;

  function automatic result_t mk_res(logic lv, logic [7:0] lb, logic sv, logic [7:0] sb,
                                     logic [2:0] st, logic ovf, logic [7:0] err,
                                     logic lst);
    result_t r;
    r.link_valid  = lv;
    r.link_byte   = lv ? lb : 8'h00;
    r.sink_valid  = sv;
    r.sink_byte   = sv ? sb : 8'h00;
    r.status      = st;
    r.overflow    = ovf;
    r.error_total = err;
    r.last        = lst;
    return r;
  endfunction

  assign can_emit    = ~res_valid_q | res_pop_i;
  assign fifo_pop_o  = (state_q == B_IDLE) & ~fifo_empty_i;
  assign idx_next    = (idx_q == IdxW'(LINE_DEPTH - 1)) ? '0 : idx_q + 1'b1;
  assign walk_last   = (LEN_W'(idx_q) + LEN_W'(1)) == cmd_q.len;
  assign is_deliver  = cmd_q.op == CMD_DELIVER;
  assign res_load    = (state_q != B_IDLE) & can_emit;
  assign walk_end    = can_emit & ((state_q == B_ACK) | ((state_q == B_TAIL) & ~is_deliver));
  assign in_walk     = (state_q == B_WALK) | (state_q == B_TAIL);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign walk_done_o = walk_done_q;

  always_comb begin
    if (state_q == B_IDLE) begin
      rd_addr = '0;
    end else if (state_q == B_WALK && can_emit) begin
      rd_addr = idx_next;
    end else begin
      rd_addr = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_mem[store_wr_i.addr[IdxW-1:0]] <= store_wr_i.data;
    end
    rdata_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cmd_q       <= '0;
      idx_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
      walk_done_q <= 1'b0;
    end else begin
      walk_done_q <= walk_end;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!fifo_empty_i) begin
            cmd_q <= fifo_data_i;
            idx_q <= '0;
            unique case (fifo_data_i.op) inside
              CMD_SINGLE: state_q <= B_SINGLE;
              CMD_DELIVER, CMD_SEND: begin
                state_q <= (fifo_data_i.len == '0) ? B_TAIL : B_WALK;
              end
              default: state_q <= B_END1;
            endcase
          end
        end
        B_SINGLE: begin
          if (can_emit) begin
            res_q <= mk_res(cmd_q.link_valid, cmd_q.link_byte, 1'b0, 8'h00, cmd_q.status,
                            cmd_q.ovf_a, cmd_q.err_a, ~cmd_q.abort);
            state_q <= cmd_q.abort ? B_ABORT : B_IDLE;
          end
        end
        B_ABORT: begin
          if (can_emit) begin
            res_q <= mk_res(1'b0, 8'h00, 1'b0, 8'h00, STS_ABORT, cmd_q.ovf_b, cmd_q.err_b,
                            1'b1);
            state_q <= B_IDLE;
          end
        end
        B_WALK: begin
          if (can_emit) begin
            res_q <= mk_res(~is_deliver, rdata_q, is_deliver, rdata_q, STS_NONE,
                            cmd_q.ovf_a, cmd_q.err_a, 1'b0);
            idx_q <= idx_next;
            if (walk_last) begin
              state_q <= B_TAIL;
            end
          end
        end
        B_TAIL: begin
          if (can_emit) begin
            if (is_deliver) begin
              res_q <= mk_res(1'b0, 8'h00, 1'b1, CHR_LF, STS_NONE, cmd_q.ovf_a, cmd_q.err_a,
                              1'b0);
              state_q <= B_ACK;
            end else begin
              res_q <= mk_res(1'b1, cmd_q.sum, 1'b0, 8'h00, STS_NONE, cmd_q.ovf_a,
                              cmd_q.err_a, 1'b1);
              state_q <= B_IDLE;
            end
          end
        end
        B_ACK: begin
          if (can_emit) begin
            res_q <= mk_res(1'b1, CHR_ACK, 1'b0, 8'h00, STS_LINE, cmd_q.ovf_a, cmd_q.err_a,
                            1'b1);
            state_q <= B_IDLE;
          end
        end
        B_END1: begin
          if (can_emit) begin
            res_q <= mk_res(1'b1, CHR_EOF, 1'b0, 8'h00, STS_NONE, cmd_q.ovf_a, cmd_q.err_a,
                            1'b0);
            state_q <= B_END2;
          end
        end
        B_END2: begin
          if (can_emit) begin
            res_q <= mk_res(1'b1, CHR_CR, 1'b0, 8'h00, STS_NONE, cmd_q.ovf_a, cmd_q.err_a,
                            1'b0);
            state_q <= B_END3;
          end
        end
        B_END3: begin
          if (can_emit) begin
            res_q <= mk_res(1'b1, CHR_QUOTE, 1'b0, 8'h00, STS_NONE, cmd_q.ovf_a,
                            cmd_q.err_a, 1'b1);
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `LCAL_NEVER(a_no_write_in_walk, store_wr_i.en && in_walk, "line store written in a walk")
  `LCAL_IMPLY(a_walk_in_range, state_q == B_WALK, LEN_W'(idx_q) < cmd_q.len, "walk past length")
  `LCAL_IMPLY(a_idle_group_closed, state_q == B_IDLE && res_valid_q, res_q.last, "open group")

endmodule

>>> rtl/line_checksum_ack_link_core.sv
// Top level of the line checksum acknowledged serial link.
// Usage:
//   Input channel (push/full): each transaction is a link byte, a timeout tick, a
//   source byte or a start-job command. Configuration (cfg_we_i, cfg_idx_i,
//   cfg_data_i) sets direction and error limit; write only while the block is idle.
//   Result channel (empty/pop): link bytes to send, delivered line bytes and
//   status, zero or more results per transaction, the final one of each group
//   marked last.
// Result path and throughput:
//   The first result of a transaction passes the command queue, the back end's
//   command register and the result register. Within a group results leave at one
//   per cycle while pop keeps pace. A line delivery or transmission walks the line
//   store via its single read port: up to LINE_DEPTH+2 results. While such a walk
//   is queued or running, full stays high; other transactions queue two deep.
// Reset: protocol idle, counters and flags cleared, error limit 10, receive
//   direction. The line store is not cleared; no clearing pass is needed.
// Stall: an untaken result holds in the output register, the back end waits,
//   the command queue fills and full rises until pop resumes.
module line_checksum_ack_link_core #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  lcal_pkg::item_t                 item_i,
  output logic                            empty,
  input  logic                            pop,
  output lcal_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [lcal_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcal_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lcal_pkg::*;

  logic      cmd_push;
  cmd_t      cmd_in, cmd_out;
  logic      fifo_full, fifo_empty, fifo_pop;
  store_wr_t store_wr;
  logic      walk_done;
  logic      res_valid;

  lcal_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(push),
    .item_i      (item_i),
    .full_o      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .fifo_full_i (fifo_full),
    .store_wr_o  (store_wr),
    .walk_done_i (walk_done)
  );

  lcal_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .data_o (cmd_out),
    .empty_o(fifo_empty)
  );

  lcal_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .fifo_data_i (cmd_out),
    .fifo_pop_o  (fifo_pop),
    .store_wr_i  (store_wr),
    .walk_done_o (walk_done),
    .res_valid_o (res_valid),
    .res_o       (result_o),
    .res_pop_i   (pop)
  );

  assign empty = ~res_valid;

endmodule
